// ===== hdl/tqfr_pkg.sv =====
// Shared types and codes for the two-queue frame replacer.
// Used by the controller, the datapath and the top level; no dependencies.
package tqfr_pkg;

	localparam logic [1:0] REQ_ACCESS = 2'd0;
	localparam logic [1:0] REQ_SET_EV = 2'd1;
	localparam logic [1:0] REQ_VICTIM = 2'd2;
	localparam logic [1:0] REQ_REMOVE = 2'd3;

	localparam logic Q_HIST  = 1'b0;
	localparam logic Q_CACHE = 1'b1;

	localparam logic [2:0] FA_NONE    = 3'd0;
	localparam logic [2:0] FA_TRACK   = 3'd1;
	localparam logic [2:0] FA_CACHE   = 3'd2;
	localparam logic [2:0] FA_SETEV   = 3'd3;
	localparam logic [2:0] FA_UNTRACK = 3'd4;

	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_INC  = 2'd1;
	localparam logic [1:0] CNT_DEC  = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [6:0] frame_num;
		logic       make_evictable;
	} req_t;

	typedef struct packed {
		logic       victim_found;
		logic [5:0] victim_frame;
		logic [6:0] evictable_count;
	} rsp_t;

	typedef struct packed {
		logic       load;
		logic       unlink_wr;
		logic       unlink_q;
		logic       push_a;
		logic       push_b;
		logic       push_q;
		logic       fin;
		logic [2:0] flag_op;
		logic [1:0] cnt_op;
		logic       found;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       make_ev;
		logic       w_valid;
		logic       tracked;
		logic       evictable;
		logic       in_cache;
		logic       victim_ok;
		logic       victim_q;
		logic       out_busy;
	} stat_t;

endpackage

// ===== hdl/tqfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tqfr_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/tqfr_datapath.sv =====
// Datapath: frame flags, queue ends, link memories, count and result register.
// Depends on tqfr_pkg and tqfr_ram; driven by tqfr_ctrl commands.
module tqfr_datapath #(
	parameter int FRAMES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tqfr_pkg::req_t req,
	input  tqfr_pkg::cmd_t cmd,
	output tqfr_pkg::stat_t st,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tqfr_pkg::rsp_t rsp
);
	import tqfr_pkg::*;

	localparam int IW = $clog2(FRAMES);
	localparam int LW = $clog2(FRAMES + 1);
	localparam logic [LW-1:0] NIL = LW'(FRAMES);

	logic [FRAMES-1:0] trk_q, ev_q, cache_q;
	logic [LW-1:0]     hh_q, ht_q, ch_q, ct_q;
	logic [LW-1:0]     total_q, total_nx;
	logic [1:0]        req_type_q;
	logic              ev_in_q, wv_q, vok_q, vq_q;
	logic [IW-1:0]     w_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic          nx_we, pv_we;
	logic [IW-1:0] nx_wa, pv_wa;
	logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
	logic [LW-1:0] push_head;
	logic          hist_ok, cache_ok;

	assign hist_ok  = ht_q != NIL;
	assign cache_ok = ct_q != NIL;
	assign push_head = cmd.push_q ? ch_q : hh_q;

	tqfr_ram #(.WIDTH(LW), .DEPTH(FRAMES)) next_ram (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(w_q), .rdata(nx_rd)
	);
	tqfr_ram #(.WIDTH(LW), .DEPTH(FRAMES)) prev_ram (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(w_q), .rdata(pv_rd)
	);

	// Link writes: unlink patches both neighbors, push uses push_a then push_b.
	always_comb begin
		nx_we = 1'b0;
		nx_wa = w_q;
		nx_wd = push_head;
		pv_we = 1'b0;
		pv_wa = w_q;
		pv_wd = NIL;
		if (cmd.unlink_wr) begin
			nx_we = pv_rd != NIL;
			nx_wa = IW'(pv_rd);
			nx_wd = nx_rd;
			pv_we = nx_rd != NIL;
			pv_wa = IW'(nx_rd);
			pv_wd = pv_rd;
		end else if (cmd.push_a) begin
			nx_we = 1'b1;
			pv_we = 1'b1;
		end else if (cmd.push_b) begin
			pv_we = push_head != NIL;
			pv_wa = IW'(push_head);
			pv_wd = LW'(w_q);
		end
	end

	always_comb begin
		total_nx = total_q;
		case (cmd.cnt_op)
			CNT_INC: total_nx = total_q + LW'(1);
			CNT_DEC: if (total_q != '0) total_nx = total_q - LW'(1);
			default: total_nx = total_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_q       <= '0;
			ev_q        <= '0;
			cache_q     <= '0;
			hh_q        <= NIL;
			ht_q        <= NIL;
			ch_q        <= NIL;
			ct_q        <= NIL;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.fin) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cmd.unlink_wr) begin
				if (pv_rd == NIL) begin
					if (cmd.unlink_q) ch_q <= nx_rd;
					else hh_q <= nx_rd;
				end
				if (nx_rd == NIL) begin
					if (cmd.unlink_q) ct_q <= pv_rd;
					else ht_q <= pv_rd;
				end
			end
			if (cmd.push_b) begin
				if (cmd.push_q) begin
					ch_q <= LW'(w_q);
					if (ch_q == NIL) ct_q <= LW'(w_q);
				end else begin
					hh_q <= LW'(w_q);
					if (hh_q == NIL) ht_q <= LW'(w_q);
				end
			end
			if (cmd.fin) begin
				case (cmd.flag_op)
					FA_TRACK: begin
						trk_q[w_q]   <= 1'b1;
						ev_q[w_q]    <= 1'b0;
						cache_q[w_q] <= 1'b0;
					end
					FA_CACHE: cache_q[w_q] <= 1'b1;
					FA_SETEV: ev_q[w_q] <= ev_in_q;
					FA_UNTRACK: begin
						trk_q[w_q]   <= 1'b0;
						ev_q[w_q]    <= 1'b0;
						cache_q[w_q] <= 1'b0;
					end
					default: ;
				endcase
				total_q <= total_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req.req_type;
			ev_in_q    <= req.make_evictable;
			vok_q      <= (total_q != '0) && (hist_ok || cache_ok);
			vq_q       <= hist_ok ? Q_HIST : Q_CACHE;
			if (req.req_type == REQ_VICTIM) begin
				wv_q <= (total_q != '0) && (hist_ok || cache_ok);
				w_q  <= hist_ok ? IW'(ht_q) : IW'(ct_q);
			end else begin
				wv_q <= 32'(req.frame_num) < FRAMES;
				w_q  <= IW'(req.frame_num);
			end
		end
		if (cmd.fin) begin
			rsp_q.victim_found    <= cmd.found;
			rsp_q.victim_frame    <= cmd.found ? 6'(w_q) : 6'd0;
			rsp_q.evictable_count <= 7'(total_nx);
		end
	end

	assign st.req_type  = req_type_q;
	assign st.make_ev   = ev_in_q;
	assign st.w_valid   = wv_q;
	assign st.tracked   = wv_q && trk_q[w_q];
	assign st.evictable = wv_q && ev_q[w_q];
	assign st.in_cache  = wv_q && cache_q[w_q];
	assign st.victim_ok = vok_q;
	assign st.victim_q  = vq_q;
	assign st.out_busy  = rsp_valid_q && rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule

// ===== hdl/tqfr_ctrl.sv =====
// Controller: plans each request and sequences the unlink and push steps.
// Depends on tqfr_pkg; drives tqfr_datapath through cmd_t.
module tqfr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            idle,
	input  tqfr_pkg::stat_t st,
	output tqfr_pkg::cmd_t  cmd
);
	import tqfr_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PLAN = 3'd1;
	localparam logic [2:0] S_URD  = 3'd2;
	localparam logic [2:0] S_UWR  = 3'd3;
	localparam logic [2:0] S_PA   = 3'd4;
	localparam logic [2:0] S_PB   = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q, state_nx;
	logic       un_q_q, do_push_q, push_q_q, found_q;
	logic [2:0] fa_q;
	logic [1:0] ca_q;

	logic       do_un, un_qsel, do_push, push_qsel, found;
	logic [2:0] fa;
	logic [1:0] ca;

	// Request decode, done once per beat on the latched frame's flags.
	always_comb begin
		do_un     = 1'b0;
		un_qsel   = st.in_cache;
		do_push   = 1'b0;
		push_qsel = st.in_cache;
		found     = 1'b0;
		fa        = FA_NONE;
		ca        = CNT_NONE;
		unique case (st.req_type)
			REQ_ACCESS: begin
				if (st.w_valid) begin
					if (!st.tracked) begin
						fa = FA_TRACK;
					end else begin
						do_un     = st.evictable;
						do_push   = st.evictable;
						push_qsel = Q_CACHE;
						if (!st.in_cache) fa = FA_CACHE;
					end
				end
			end
			REQ_SET_EV: begin
				if (st.tracked && (st.evictable != st.make_ev)) begin
					fa      = FA_SETEV;
					do_push = st.make_ev;
					do_un   = !st.make_ev;
					ca      = st.make_ev ? CNT_INC : CNT_DEC;
				end
			end
			REQ_VICTIM: begin
				if (st.victim_ok) begin
					found   = 1'b1;
					do_un   = 1'b1;
					un_qsel = st.victim_q;
					fa      = FA_UNTRACK;
					ca      = CNT_DEC;
				end
			end
			REQ_REMOVE: begin
				if (st.tracked) begin
					fa    = FA_UNTRACK;
					do_un = st.evictable;
					if (st.evictable) ca = CNT_DEC;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (req_valid) state_nx = S_PLAN;
			S_PLAN: state_nx = do_un ? S_URD : (do_push ? S_PA : S_FIN);
			S_URD:  state_nx = S_UWR;
			S_UWR:  state_nx = do_push_q ? S_PA : S_FIN;
			S_PA:   state_nx = S_PB;
			S_PB:   state_nx = S_FIN;
			S_FIN:  if (!st.out_busy) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			un_q_q    <= 1'b0;
			do_push_q <= 1'b0;
			push_q_q  <= 1'b0;
			found_q   <= 1'b0;
			fa_q      <= FA_NONE;
			ca_q      <= CNT_NONE;
		end else begin
			state_q <= state_nx;
			if (state_q == S_PLAN) begin
				un_q_q    <= un_qsel;
				do_push_q <= do_push;
				push_q_q  <= push_qsel;
				found_q   <= found;
				fa_q      <= fa;
				ca_q      <= ca;
			end
		end
	end

	assign idle = state_q == S_IDLE;

	always_comb begin
		cmd           = '0;
		cmd.load      = idle && req_valid;
		cmd.unlink_wr = state_q == S_UWR;
		cmd.unlink_q  = un_q_q;
		cmd.push_a    = state_q == S_PA;
		cmd.push_b    = state_q == S_PB;
		cmd.push_q    = push_q_q;
		cmd.found     = found_q;
		if (state_q == S_FIN && !st.out_busy) begin
			cmd.fin     = 1'b1;
			cmd.flag_op = fa_q;
			cmd.cnt_op  = ca_q;
		end
	end
endmodule

// ===== hdl/two_queue_frame_replacer_unit.sv =====
// Channel | dir | payload | handshake
// req     | in  | req_t   | req_valid / req_stall
// rsp     | out | rsp_t   | rsp_valid / rsp_stall
//
// Each beat is decoded, then takes an unlink (read and patch of the link memories)
// and/or a push (two writes on the single-write prev memory) as the request needs.
// One request is worked on at a time; the next is taken once the result is in
// the output register. Reset clears flags, queue ends and the count at once.
// A stalled result holds the block in its final step until it is taken.
// Top level of the two-queue frame replacer; depends on tqfr_pkg, tqfr_ctrl, tqfr_datapath.
module two_queue_frame_replacer_unit #(
	parameter int FRAMES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  tqfr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tqfr_pkg::rsp_t rsp
);
	import tqfr_pkg::*;

	cmd_t  cmd;
	stat_t st;
	logic  idle;

	assign req_stall = !idle;

	tqfr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .idle(idle), .st(st), .cmd(cmd)
	);

	tqfr_datapath #(.FRAMES(FRAMES)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .st(st),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);
endmodule

// ===== tb/tb_two_queue_frame_replacer_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the two-queue frame replacer unit.
// Depends on tqfr_pkg and two_queue_frame_replacer_unit; drives requests and checks every result beat.
module tb_two_queue_frame_replacer_unit;
	import tqfr_pkg::*;

	localparam int NFRAMES = 64;
	localparam int NIL = NFRAMES;
	localparam int RANDOM_ITEMS = 1830;
	localparam int CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	two_queue_frame_replacer_unit #(.FRAMES(NFRAMES)) dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// Predictor state for the replacer.
	bit tracked_q[NFRAMES];
	bit evict_q[NFRAMES];
	bit cached_q[NFRAMES];
	int nxt[NFRAMES];
	int prv[NFRAMES];
	int hist_head, hist_tail, cache_head, cache_tail;
	int ev_total;

	rsp_t pending_rsp[$];
	int errors;
	int cycles;
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void link_head(input int f, inout int head, inout int tail);
		nxt[f] = head;
		prv[f] = NIL;
		if (head < NIL) prv[head] = f;
		else tail = f;
		head = f;
	endfunction

	function automatic void unlink(input int f, inout int head, inout int tail);
		int p;
		int n;
		p = prv[f];
		n = nxt[f];
		if (p < NIL) nxt[p] = n;
		else head = n;
		if (n < NIL) prv[n] = p;
		else tail = p;
	endfunction

	function automatic void drop_frame(input int f);
		tracked_q[f] = 0;
		evict_q[f] = 0;
		cached_q[f] = 0;
	endfunction

	function automatic rsp_t predict_replacement(input req_t r);
		rsp_t o;
		int f;
		bit ok;
		o = '0;
		f = r.frame_num;
		ok = f < NFRAMES;
		case (r.req_type)
			REQ_ACCESS: begin
				if (ok) begin
					if (!tracked_q[f]) begin
						tracked_q[f] = 1;
						evict_q[f] = 0;
						cached_q[f] = 0;
					end else if (cached_q[f]) begin
						if (evict_q[f]) begin
							unlink(f, cache_head, cache_tail);
							link_head(f, cache_head, cache_tail);
						end
					end else begin
						if (evict_q[f]) begin
							unlink(f, hist_head, hist_tail);
							link_head(f, cache_head, cache_tail);
						end
						cached_q[f] = 1;
					end
				end
			end
			REQ_SET_EV: begin
				if (ok && tracked_q[f] && evict_q[f] != r.make_evictable) begin
					evict_q[f] = r.make_evictable;
					if (r.make_evictable) begin
						if (cached_q[f]) link_head(f, cache_head, cache_tail);
						else link_head(f, hist_head, hist_tail);
						ev_total++;
					end else begin
						if (cached_q[f]) unlink(f, cache_head, cache_tail);
						else unlink(f, hist_head, hist_tail);
						if (ev_total > 0) ev_total--;
					end
				end
			end
			REQ_VICTIM: begin
				if (ev_total != 0) begin
					if (hist_tail < NIL) begin
						f = hist_tail;
						unlink(f, hist_head, hist_tail);
						o.victim_found = 1;
					end else if (cache_tail < NIL) begin
						f = cache_tail;
						unlink(f, cache_head, cache_tail);
						o.victim_found = 1;
					end
					if (o.victim_found) begin
						drop_frame(f);
						if (ev_total > 0) ev_total--;
						o.victim_frame = f[5:0];
					end
				end
			end
			default: begin
				if (ok && tracked_q[f]) begin
					if (evict_q[f]) begin
						if (cached_q[f]) unlink(f, cache_head, cache_tail);
						else unlink(f, hist_head, hist_tail);
						if (ev_total > 0) ev_total--;
					end
					drop_frame(f);
				end
			end
		endcase
		o.evictable_count = ev_total[6:0];
		return o;
	endfunction

	// Receiver side: random stalls except during the quiet stretch.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: unexpected result beat %p", $time, rsp);
					errors++;
				end else begin
					rsp_t e;
					e = pending_rsp.pop_front();
					if (rsp.victim_found !== e.victim_found || rsp.victim_frame !== e.victim_frame
							|| rsp.evictable_count !== e.evictable_count) begin
						$display("%0t: mismatch expected %p actual %p", $time, e, rsp);
						errors++;
					end
				end
			end
			rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 19);
		end
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Sends one request beat; an expected result given as known is also checked against
	// the predictor so a typing slip in the table shows up too. Valid stays high after
	// the beat so that a following beat can go out with no gap.
	task automatic send_request(input req_t r, input bit has_known, input rsp_t known);
		rsp_t p;
		while (!quiet && $urandom_range(99) < 19) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		p = predict_replacement(r);
		if (has_known && p != known) begin
			$display("%0t: table row expected %p predictor %p", $time, known, p);
			errors++;
		end
		pending_rsp.push_back(p);
	endtask

	function automatic req_t mk(input logic [1:0] t, input int f, input bit ev);
		req_t r;
		r.req_type = t;
		r.frame_num = f[6:0];
		r.make_evictable = ev;
		return r;
	endfunction

	function automatic rsp_t rs(input bit fnd, input int f, input int c);
		rsp_t o;
		o.victim_found = fnd;
		o.victim_frame = f[5:0];
		o.evictable_count = c[6:0];
		return o;
	endfunction

	typedef struct {
		req_t r;
		bit   known;
		rsp_t e;
	} row_t;

	row_t directed[$];
	int busy_frame;

	initial begin
		req_t r;
		int k;
		errors = 0;
		cycles = 0;
		quiet = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		for (int i = 0; i < NFRAMES; i++) begin
			tracked_q[i] = 0; evict_q[i] = 0; cached_q[i] = 0; nxt[i] = NIL; prv[i] = NIL;
		end
		hist_head = NIL; hist_tail = NIL; cache_head = NIL; cache_tail = NIL; ev_total = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: empty replacer, extremes, out-of-range ids, pinned cache path.
		directed.push_back('{mk(REQ_VICTIM, 0, 0), 1, rs(0, 0, 0)});
		directed.push_back('{mk(REQ_ACCESS, 127, 1), 1, rs(0, 0, 0)});
		directed.push_back('{mk(REQ_SET_EV, 64, 1), 1, rs(0, 0, 0)});
		directed.push_back('{mk(REQ_SET_EV, 5, 1), 1, rs(0, 0, 0)});
		directed.push_back('{mk(REQ_REMOVE, 5, 0), 1, rs(0, 0, 0)});
		directed.push_back('{mk(REQ_ACCESS, 0, 0), 1, rs(0, 0, 0)});
		directed.push_back('{mk(REQ_ACCESS, 63, 0), 1, rs(0, 0, 0)});
		directed.push_back('{mk(REQ_SET_EV, 0, 1), 1, rs(0, 0, 1)});
		directed.push_back('{mk(REQ_SET_EV, 0, 1), 1, rs(0, 0, 1)});
		directed.push_back('{mk(REQ_SET_EV, 63, 1), 1, rs(0, 0, 2)});
		directed.push_back('{mk(REQ_ACCESS, 63, 0), 0, '0});
		directed.push_back('{mk(REQ_VICTIM, 0, 0), 1, rs(1, 0, 1)});
		directed.push_back('{mk(REQ_VICTIM, 0, 0), 1, rs(1, 63, 0)});
		directed.push_back('{mk(REQ_ACCESS, 42, 0), 0, '0});
		directed.push_back('{mk(REQ_ACCESS, 42, 0), 0, '0});
		directed.push_back('{mk(REQ_ACCESS, 21, 0), 0, '0});
		directed.push_back('{mk(REQ_SET_EV, 42, 1), 0, '0});
		directed.push_back('{mk(REQ_SET_EV, 21, 1), 0, '0});
		directed.push_back('{mk(REQ_ACCESS, 42, 1), 0, '0});
		directed.push_back('{mk(REQ_SET_EV, 21, 0), 0, '0});
		directed.push_back('{mk(REQ_VICTIM, 0, 0), 0, '0});
		directed.push_back('{mk(REQ_REMOVE, 21, 1), 0, '0});
		directed.push_back('{mk(REQ_VICTIM, 0, 0), 1, rs(0, 0, 0)});
		foreach (directed[i]) send_request(directed[i].r, directed[i].known, directed[i].e);
		req_valid <= 1'b0;

		// Hold off until the block has drained everything.
		while (pending_rsp.size() != 0) @(posedge clk);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 600 && n < 800);
			// Mostly a smaller id pool so that frames cycle through both queues.
			k = $urandom_range(99);
			if (k < 70) busy_frame = $urandom_range(15);
			else if (k < 92) busy_frame = $urandom_range(NFRAMES - 1);
			else busy_frame = $urandom_range(127);
			k = $urandom_range(99);
			if (k < 38) r = mk(REQ_ACCESS, busy_frame, $urandom_range(1));
			else if (k < 72) r = mk(REQ_SET_EV, busy_frame, ($urandom_range(99) < 70));
			else if (k < 90) r = mk(REQ_VICTIM, busy_frame, $urandom_range(1));
			else r = mk(REQ_REMOVE, busy_frame, $urandom_range(1));
			send_request(r, 0, '0);
		end
		quiet = 0;
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
